[rtl/fdbb_pkg.sv]
// Package of shared types, constants and functions for the frame delta bounding box.
`timescale 1ns / 1ps

package fdbb_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned DeltaW     = 18;
  localparam int unsigned PosW       = 10;
  localparam int unsigned SpanW      = 11;
  localparam int unsigned CfgDataW   = 11;
  localparam int unsigned CfgIdxW    = 1;

  localparam int unsigned MaxWidthDefault  = 1024;
  localparam int unsigned MaxHeightDefault = 1024;
  localparam int unsigned FrameWidthReset  = 320;
  localparam int unsigned FrameHeightReset = 200;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] old_red;
    logic [ChanW-1:0] old_green;
    logic [ChanW-1:0] old_blue;
    logic [ChanW-1:0] new_red;
    logic [ChanW-1:0] new_green;
    logic [ChanW-1:0] new_blue;
  } pix_t;

  typedef struct packed {
    logic [DeltaW-1:0] pixel_delta;
    logic              frame_done;
    logic              box_empty;
    logic [PosW-1:0]   box_left;
    logic [PosW-1:0]   box_top;
    logic [SpanW-1:0]  box_width;
    logic [SpanW-1:0]  box_height;
  } res_t;

  // Square of the absolute difference of two channel values.
  function automatic logic [2*ChanW-1:0] sq_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    logic [ChanW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return (2*ChanW)'(d) * (2*ChanW)'(d);
  endfunction

  // Index of the last column or row for a size register, with the size saturated to 1..top.
  function automatic int unsigned last_index(logic [CfgDataW-1:0] v, int unsigned top);
    int unsigned s;
    s = 32'(v);
    if (s == 0) begin
      return 0;
    end else if (s > top) begin
      return top - 1;
    end
    return s - 1;
  endfunction

endpackage

[rtl/fdbb_pix_if.sv]
// Channel interfaces for pixel items in and result items out.
`timescale 1ns / 1ps

interface fdbb_pix_if;
  import fdbb_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fdbb_res_if;
  import fdbb_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/frame_delta_bounding_box.sv]
// Top level of the frame delta bounding box: pixel delta and box of change per frame.
// The block takes one pixel pair per clock, while the output is not stalled, and gives
// one result item for each. A pixel is held in an input register, and the squared
// difference, the raster counters and the box tracking are all resolved in the single
// step from that register into the result register, which holds the result item while
// the output is stalled; so the sustained rate is one item per clock when the output
// is not stalled. While a finished result waits, the input side accepts a pixel only
// into an empty input register. The frame size registers are saturated to
// 1..MAX_WIDTH and 1..MAX_HEIGHT when written; the box is reported on the last pixel of
// each frame, including that pixel, and the tracking then starts afresh.
`timescale 1ns / 1ps

module frame_delta_bounding_box #(
  parameter int unsigned MAX_WIDTH  = fdbb_pkg::MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = fdbb_pkg::MaxHeightDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fdbb_pix_if.sink                       pix_i,
  fdbb_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [fdbb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fdbb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import fdbb_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [ColW-1:0] ColLastRst =
    ColW'(last_index(CfgDataW'(FrameWidthReset), MAX_WIDTH));
  localparam logic [RowW-1:0] RowLastRst =
    RowW'(last_index(CfgDataW'(FrameHeightReset), MAX_HEIGHT));
  localparam logic [ColW-1:0] ColMinRst = ColW'(MAX_WIDTH - 1);
  localparam logic [RowW-1:0] RowMinRst = RowW'(MAX_HEIGHT - 1);

  logic [ColW-1:0] col_last_q;
  logic [RowW-1:0] row_last_q;

  logic            s1_v_q;
  pix_t            s1_q;
  logic            out_v_q;
  res_t            out_q;
  res_t            res_d;

  logic [ColW-1:0] col_q, col_d, min_col_q, min_col_d, max_col_q, max_col_d;
  logic [RowW-1:0] row_q, row_d, min_row_q, min_row_d, max_row_q, max_row_d;
  logic            any_q, any_d;

  logic            out_adv;
  logic            s1_adv;
  logic            changed;
  logic            last_col;
  logic            last_row;
  logic            done;
  logic [ColW:0]   span_col;
  logic [RowW:0]   span_row;

  assign out_adv     = !out_v_q || res_o.ready;
  assign s1_adv      = s1_v_q && out_adv;
  assign pix_i.ready = !s1_v_q || out_adv;
  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= ColLastRst;
      row_last_q <= RowLastRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegFrameWidth:  col_last_q <= ColW'(last_index(cfg_data_i, MAX_WIDTH));
        RegFrameHeight: row_last_q <= RowW'(last_index(cfg_data_i, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  always_comb begin
    changed = (s1_q.old_red != s1_q.new_red) || (s1_q.old_green != s1_q.new_green) ||
              (s1_q.old_blue != s1_q.new_blue);
    last_col = col_q >= col_last_q;
    last_row = row_q >= row_last_q;
    done     = last_col && last_row;

    min_col_d = (changed && col_q < min_col_q) ? col_q : min_col_q;
    max_col_d = (changed && col_q > max_col_q) ? col_q : max_col_q;
    min_row_d = (changed && row_q < min_row_q) ? row_q : min_row_q;
    max_row_d = (changed && row_q > max_row_q) ? row_q : max_row_q;
    any_d     = any_q || changed;
    span_col  = {1'b0, max_col_d} - {1'b0, min_col_d} + (ColW+1)'(1);
    span_row  = {1'b0, max_row_d} - {1'b0, min_row_d} + (RowW+1)'(1);

    res_d.pixel_delta = DeltaW'(sq_diff(s1_q.old_red, s1_q.new_red)) +
                        DeltaW'(sq_diff(s1_q.old_green, s1_q.new_green)) +
                        DeltaW'(sq_diff(s1_q.old_blue, s1_q.new_blue));
    res_d.frame_done  = done;
    res_d.box_empty   = done && !any_d;
    res_d.box_left    = '0;
    res_d.box_top     = '0;
    res_d.box_width   = '0;
    res_d.box_height  = '0;
    if (done && any_d) begin
      res_d.box_left   = PosW'(min_col_d);
      res_d.box_top    = PosW'(min_row_d);
      res_d.box_width  = SpanW'(span_col);
      res_d.box_height = SpanW'(span_row);
    end

    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (done) begin
      col_d     = '0;
      row_d     = '0;
      min_col_d = ColMinRst;
      max_col_d = '0;
      min_row_d = RowMinRst;
      max_row_d = '0;
      any_d     = 1'b0;
    end else if (last_col) begin
      col_d = '0;
      row_d = row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      min_col_q <= ColMinRst;
      max_col_q <= '0;
      min_row_q <= RowMinRst;
      max_row_q <= '0;
      any_q     <= 1'b0;
    end else begin
      if (pix_i.ready) begin
        s1_v_q <= pix_i.valid;
      end
      if (out_adv) begin
        out_v_q <= s1_v_q;
      end
      if (s1_adv) begin
        col_q     <= col_d;
        row_q     <= row_d;
        min_col_q <= min_col_d;
        max_col_q <= max_col_d;
        min_row_q <= min_row_d;
        max_row_q <= max_row_d;
        any_q     <= any_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_i.ready && pix_i.valid) begin
      s1_q <= pix_i.data;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

endmodule

[rtl/fdbb_chk.sv]
// Checker of the result port of the frame delta bounding box, with its bind statement.
`timescale 1ns / 1ps

module fdbb_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input fdbb_pkg::res_t res_data_i
);
  import fdbb_pkg::*;

  // A stalled result item must stay in place.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result item changed while stalled");

  // Box fields carry nothing except on the last pixel of a frame.
  a_box_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_data_i.frame_done |->
      !res_data_i.box_empty && res_data_i.box_left == '0 && res_data_i.box_top == '0 &&
      res_data_i.box_width == '0 && res_data_i.box_height == '0)
    else $error("box fields set away from frame end");

  // An empty frame reports a zero box, and a changed pixel cannot close an empty frame.
  a_box_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.box_empty |->
      res_data_i.pixel_delta == '0 && res_data_i.box_width == '0 &&
      res_data_i.box_height == '0 && res_data_i.box_left == '0 && res_data_i.box_top == '0)
    else $error("empty box reported with content");

  // A box that is not empty spans at least one column and one row.
  a_box_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.frame_done && !res_data_i.box_empty |->
      res_data_i.box_width != '0 && res_data_i.box_height != '0)
    else $error("non-empty box with zero span");

endmodule

bind frame_delta_bounding_box fdbb_chk u_fdbb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
